### src/assert_macros.svh
// Assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

### src/lhe_pkg.sv
// ----------------------------------------------------------------------------
// lhe_pkg
// Types and constants of the local histogram equalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package lhe_pkg;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned LW_W  = 11;
	localparam int unsigned WIN_W = 6;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             frame_start;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] equalized_value;
		logic             line_end;
		logic             window_error;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] data;
	} cfg_item_t;

	// controller -> datapath
	typedef struct packed {
		logic setup;   // latch pixel, write store, decide result
		logic rd_req;  // issue store read for current row/column
		logic rd_cmp;  // compare returned store byte
		logic tgt;     // returned byte is the centre
		logic div_go;  // start divide
		logic div_step;
		logic advance; // set in the setup state; the datapath does not use it
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emit;      // a result follows
		logic err;       // window wider than line
		logic scan_last; // last read issued
		logic div_done;
	} dp_stat_t;
endpackage
`default_nettype wire

### src/lhe_stream_if.sv
// ----------------------------------------------------------------------------
// lhe_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface lhe_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/lhe_ctrl.sv
// ----------------------------------------------------------------------------
// lhe_ctrl
// Sequencer: accept, window scan, divide, output.
// ----------------------------------------------------------------------------
`default_nettype none
module lhe_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            out_busy,
	output logic                 out_load,
	input  wire lhe_pkg::dp_stat_t stat,
	output lhe_pkg::dp_cmd_t     cmd
);
	typedef enum logic [2:0] {S_IDLE, S_SETUP, S_TGT, S_TGTW, S_SCAN, S_DRAIN, S_DIV, S_OUT}
		state_t;
	state_t state_q;
	logic [1:0] drain_q;

	always_comb begin
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		out_load = 1'b0;
		cmd.setup = (state_q == S_IDLE) && in_valid;
		case (state_q)
			S_TGT: cmd.rd_req = 1'b1;
			S_TGTW: ;
			S_SCAN: begin
				cmd.rd_req = 1'b1;
				cmd.rd_cmp = 1'b0;
			end
			S_OUT: out_load = !out_busy;
			default: ;
		endcase
		cmd.tgt    = (state_q == S_TGTW);
		cmd.rd_cmp = (state_q == S_SCAN && drain_q != 2'd0) || (state_q == S_DRAIN);
		cmd.div_go = (state_q == S_DRAIN) && (drain_q == 2'd1);
		cmd.div_step = (state_q == S_DIV);
		cmd.advance = (state_q == S_SETUP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			drain_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SETUP;
				S_SETUP: begin
					if (stat.err) state_q <= S_OUT;
					else if (stat.emit) state_q <= S_TGT;
					else state_q <= S_IDLE;
				end
				S_TGT: state_q <= S_TGTW;
				S_TGTW: begin
					state_q <= S_SCAN;
					drain_q <= 2'd0;
				end
				S_SCAN: begin
					drain_q <= 2'd1;
					if (stat.scan_last) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					state_q <= S_DIV;
				end
				S_DIV: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### src/lhe_datapath.sv
// ----------------------------------------------------------------------------
// lhe_datapath
// Line store, position counters, window count and restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module lhe_datapath #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_WIN   = 63
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lhe_pkg::in_item_t          in_item,
	input  wire lhe_pkg::dp_cmd_t           cmd,
	output lhe_pkg::dp_stat_t               stat,
	input  wire logic [lhe_pkg::LW_W-1:0]   line_width,
	input  wire logic [lhe_pkg::WIN_W-1:0]  win_width,
	input  wire logic [lhe_pkg::WIN_W-1:0]  win_height,
	output lhe_pkg::out_item_t              result
);
	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned SW = $clog2(MAX_WIN);
	localparam int unsigned RW = $clog2(MAX_WIN + 1);
	localparam int unsigned NW = 2 * RW;   // count / product width
	localparam int unsigned QW = NW + 8;   // dividend width

	logic [lhe_pkg::PIX_W-1:0] mem [MAX_WIN*MAX_WIDTH];
	logic [lhe_pkg::PIX_W-1:0] rd_q;

	logic [CW-1:0] col_q, colc_q;
	logic [RW-1:0] rows_q;
	logic [SW-1:0] slot_q, sslot_q;
	logic [RW-1:0] ww_q, wh_q;
	logic [CW:0]   lw_q;
	logic          last_q;
	logic [RW-1:0] r_q, c_q;
	logic [SW-1:0] rslot_q;
	logic [lhe_pkg::PIX_W-1:0] tgt_q;
	logic [NW-1:0] cnt_q, prod_q;
	logic [QW-1:0] rem_q;
	logic [lhe_pkg::PIX_W-1:0] quo_q;
	logic [$clog2(QW+1)-1:0] dcnt_q;
	logic tgt_phase_q;
	logic emit_q, err_q;

	logic [CW-1:0] col_n;
	logic [RW-1:0] ww_n, wh_n;
	logic [CW:0]   lw_n;
	logic [SW-1:0] slot_n, rows_idx;
	logic [RW-1:0] rows_n;
	logic          last_n;
	logic [$clog2(MAX_WIN*MAX_WIDTH)-1:0] waddr, raddr;
	logic [SW-1:0] rd_slot;
	logic [CW-1:0] rd_col;
	logic [SW:0]   back;
	logic [SW:0]   sdiff;

	always_comb begin
		ww_n = (win_width == '0) ? RW'(1) : (RW'(win_width) > RW'(MAX_WIN) ? RW'(MAX_WIN)
			: RW'(win_width));
		wh_n = (win_height == '0) ? RW'(1) : (RW'(win_height) > RW'(MAX_WIN) ? RW'(MAX_WIN)
			: RW'(win_height));
		lw_n = (line_width == '0) ? (CW+1)'(1) : ((32'(line_width) > MAX_WIDTH) ?
			(CW+1)'(MAX_WIDTH) : (CW+1)'(line_width));
		col_n = in_item.frame_start ? '0 : col_q;
		slot_n = in_item.frame_start ? '0 : slot_q;
		rows_n = in_item.frame_start ? '0 : rows_q;
		last_n = ((CW+1)'(col_n) >= lw_n - (CW+1)'(1));
		rows_idx = slot_n;
		waddr = $bits(waddr)'(32'(slot_n) * MAX_WIDTH + 32'(col_n));
		// slot of row "back" lines above current
		back = tgt_phase_q ? (SW+1)'(wh_q - RW'(1) - (wh_q >> 1)) : (SW+1)'(r_q);
		sdiff = (SW+1)'(sslot_q) - back;
		rd_slot = sdiff[SW] ? SW'(sdiff + (SW+1)'(MAX_WIN)) : SW'(sdiff);
		rd_col = tgt_phase_q ? CW'(colc_q - CW'(ww_q) + CW'(1) + CW'(ww_q >> 1))
			: CW'(colc_q - CW'(ww_q) + CW'(1) + CW'(c_q));
		raddr = $bits(raddr)'(32'(rd_slot) * MAX_WIDTH + 32'(rd_col));
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) mem[waddr] <= in_item.pixel_value;
		if (cmd.rd_req) rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			rows_q <= '0;
			slot_q <= '0;
			emit_q <= 1'b0;
			err_q <= 1'b0;
			tgt_phase_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			dcnt_q <= '0;
			ww_q <= '0;
			wh_q <= '0;
			lw_q <= '0;
			colc_q <= '0;
			sslot_q <= '0;
			last_q <= 1'b0;
			tgt_q <= '0;
			cnt_q <= '0;
			prod_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			if (cmd.setup) begin
				ww_q <= ww_n;
				wh_q <= wh_n;
				lw_q <= lw_n;
				colc_q <= col_n;
				sslot_q <= slot_n;
				last_q <= last_n;
				err_q <= (32'(ww_n) > 32'(lw_n));
				emit_q <= (32'(rows_n) + 1 >= 32'(wh_n)) && (32'(col_n) + 1 >= 32'(ww_n));
				tgt_phase_q <= 1'b1;
				r_q <= '0;
				c_q <= '0;
				cnt_q <= '0;
				quo_q <= '0;
				if (last_n) begin
					col_q <= '0;
					if (32'(rows_n) < MAX_WIN) rows_q <= rows_n + RW'(1);
					else rows_q <= rows_n;
					slot_q <= (32'(slot_n) + 1 >= MAX_WIN) ? '0 : SW'(slot_n + SW'(1));
				end else begin
					col_q <= CW'(col_n + CW'(1));
					rows_q <= rows_n;
					slot_q <= slot_n;
				end
			end
			if (cmd.rd_req) begin
				if (tgt_phase_q) tgt_phase_q <= 1'b0;
				else if (c_q == ww_q - RW'(1)) begin
					c_q <= '0;
					r_q <= r_q + RW'(1);
				end else c_q <= c_q + RW'(1);
			end
			if (cmd.tgt) tgt_q <= rd_q;
			if (cmd.rd_cmp && rd_q < tgt_q) cnt_q <= cnt_q + NW'(1);
			if (cmd.div_go) begin
				prod_q <= NW'(ww_q) * NW'(wh_q);
				dcnt_q <= ($bits(dcnt_q))'(9);
			end
			if (cmd.div_step) begin
				if (dcnt_q == ($bits(dcnt_q))'(9)) begin
					rem_q <= {cnt_q, 8'd0};
					dcnt_q <= dcnt_q - 1'b1;
				end else if (dcnt_q != '0) begin
					// restoring division, quotient bit from MSB down
					if (({1'b0, rem_q} >> (dcnt_q - 1'b1)) >= {{(QW-NW+1){1'b0}}, prod_q}) begin
						rem_q <= rem_q - (QW'(prod_q) << (dcnt_q - 1'b1));
						quo_q[3'(dcnt_q - 1'b1)] <= 1'b1;
					end
					dcnt_q <= dcnt_q - 1'b1;
				end
			end
		end
	end

	assign stat.emit = emit_q;
	assign stat.err = err_q;
	assign stat.scan_last = !tgt_phase_q && (r_q == wh_q - RW'(1)) && (c_q == ww_q - RW'(1));
	assign stat.div_done = cmd.div_step && (dcnt_q == '0);
	assign result.equalized_value = err_q ? '0 : quo_q;
	assign result.line_end = err_q ? 1'b0 : last_q;
	assign result.window_error = err_q;
	logic unused;
	assign unused = ^{rows_idx, lw_q, cmd.advance};
endmodule
`default_nettype wire

### src/local_histogram_equalizer.sv
// ----------------------------------------------------------------------------
// local_histogram_equalizer
// Sliding-window rank equalizer over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  : sink channel of pixel_value / frame_start in raster order.
//   res_out : source channel of equalized_value / line_end / window_error.
//   cfg     : register writes (0 line_width, 1 win_width, 2 win_height),
//             taken at any time, to be issued only while idle.
// Each pixel is written into a line store of MAX_WIN lines. When it closes
// a window, the store is read one byte a cycle: the centre, then all
// win_width*win_height pixels, counted against the centre; a restoring
// divider then gives 8 quotient bits. The block takes a new pixel only
// once it is through with the last one. A result is held in the output
// register until taken; a stalled receiver holds the block. Reset clears
// position and registers; the line store has no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module local_histogram_equalizer #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_WIN   = 63
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lhe_stream_if.sink   pix_in,
	lhe_stream_if.source res_out,
	lhe_stream_if.sink   cfg
);
	logic [lhe_pkg::LW_W-1:0]  line_width_q;
	logic [lhe_pkg::WIN_W-1:0] win_width_q, win_height_q;
	lhe_pkg::dp_cmd_t  cmd;
	lhe_pkg::dp_stat_t stat;
	lhe_pkg::out_item_t result;
	lhe_pkg::cfg_item_t cw;
	logic out_load, out_valid_q;
	lhe_pkg::out_item_t out_q;

	assign cw = cfg.data;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= lhe_pkg::LW_W'(1024);
			win_width_q  <= lhe_pkg::WIN_W'(3);
			win_height_q <= lhe_pkg::WIN_W'(3);
		end else if (cfg.valid) begin
			case (cw.index)
				lhe_pkg::REG_LINE_WIDTH: line_width_q <= cw.data;
				lhe_pkg::REG_WIN_WIDTH:  win_width_q  <= cw.data[lhe_pkg::WIN_W-1:0];
				lhe_pkg::REG_WIN_HEIGHT: win_height_q <= cw.data[lhe_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	lhe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(pix_in.valid), .in_ready(pix_in.ready),
		.out_busy(out_valid_q && !res_out.ready), .out_load(out_load), .stat(stat), .cmd(cmd)
	);

	lhe_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_WIN(MAX_WIN)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(pix_in.data), .cmd(cmd), .stat(stat),
		.line_width(line_width_q), .win_width(win_width_q), .win_height(win_height_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (res_out.ready) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) if (out_load) out_q <= result;

	assign res_out.valid = out_valid_q;
	assign res_out.data = out_q;
endmodule
`default_nettype wire

### src/lhe_checker.sv
// ----------------------------------------------------------------------------
// lhe_checker
// Port-level checks of the equalizer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lhe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire lhe_pkg::out_item_t out_data
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && out_data.window_error, out_data.equalized_value == '0 && !out_data.line_end, "error result not zero")
	`ASSERT_NEXT(a_one_in, clk, arst_n, in_valid && in_ready, !in_ready, "second transfer while busy")
endmodule
bind local_histogram_equalizer lhe_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(pix_in.valid), .in_ready(pix_in.ready),
	.out_valid(res_out.valid), .out_ready(res_out.ready), .out_data(res_out.data)
);
`default_nettype wire
